// File: sv/sorted_store_binary_search_macros.svh
// Assertion macros for the sorted store with binary search.
// Included by the top level; no other dependencies.
`ifndef SORTED_STORE_BINARY_SEARCH_MACROS_SVH
`define SORTED_STORE_BINARY_SEARCH_MACROS_SVH

`ifndef ASSERT_OFF
// Check that an implication holds on every rising clock edge outside reset
`define SSBS_ASSERT_IMPL(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("implication check failed");
// Check that a condition never holds outside reset
`define SSBS_ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("forbidden condition seen");
`else
`define SSBS_ASSERT_IMPL(lbl, clk, rstn, prop)
`define SSBS_ASSERT_NEVER(lbl, clk, rstn, cond)
`endif

`endif

// File: sv/ssbs_pkg.sv
// Shared types and constants for the sorted store with binary search.
// No dependencies; imported by every module of the block.
package ssbs_pkg;

  localparam int DEPTH = 1024;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int VAL_W = 31;
  localparam int POS_W = 10;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_LOAD   = 2'd1,
    OP_SEARCH = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    PR_IDLE,
    PR_RUN,
    PR_DONE
  } probe_state_e;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] value;
  } ssbs_req_t;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] position;
    logic             dropped;
  } ssbs_rsp_t;

  // Compare outcome of one cell against a search key
  typedef struct packed {
    logic lt;
    logic eq;
  } cell_flags_t;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] position;
  } probe_rsp_t;

endpackage

// File: sv/ssbs_cell.sv
// One cell of the sorted chain: holds one entry, shifts on insert, flags a key.
// Depends on ssbs_pkg.
module ssbs_cell (
  input  logic                      clk_i,
  input  logic                      load_i,
  input  logic                      cmp_i,
  input  logic [ssbs_pkg::VAL_W-1:0] data_i,
  input  logic                      key_neg_i,
  input  logic                      occ_i,
  input  logic                      tail_i,
  input  logic [ssbs_pkg::VAL_W-1:0] prev_val_i,
  input  logic                      prev_gt_i,
  output logic [ssbs_pkg::VAL_W-1:0] val_o,
  output logic                      gt_o,
  output ssbs_pkg::cell_flags_t      flags_o
);
  import ssbs_pkg::*;

  logic [VAL_W-1:0] val_q, val_d;
  cell_flags_t      flags_q;
  logic             gt, eq, take_new;

  assign gt = val_q > data_i;
  assign eq = val_q == data_i;

  // Take a new entry when this is the free slot or the entry moves up
  assign take_new = tail_i || (occ_i && gt);

  always_comb begin
    val_d = val_q;
    if (load_i && take_new) begin
      val_d = prev_gt_i ? prev_val_i : data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  // Capture compare flags for the search that follows
  always_ff @(posedge clk_i) begin
    if (cmp_i) begin
      flags_q.lt <= !key_neg_i && !gt && !eq;
      flags_q.eq <= !key_neg_i && eq;
    end
  end

  assign val_o   = val_q;
  assign gt_o    = gt;
  assign flags_o = flags_q;

endmodule

// File: sv/ssbs_probe.sv
// Binary search sequencer: one probe per cycle over the cells' compare flags.
// Depends on ssbs_pkg.
module ssbs_probe (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [ssbs_pkg::CNT_W-1:0]  count_i,
  input  ssbs_pkg::cell_flags_t       flags_i [ssbs_pkg::DEPTH],
  input  logic                        ack_i,
  output logic                        busy_o,
  output logic                        done_o,
  output ssbs_pkg::probe_rsp_t        rsp_o
);
  import ssbs_pkg::*;

  probe_state_e     state_q, state_d;
  logic [CNT_W-1:0] lo_q, lo_d, end_q, end_d;
  probe_rsp_t       rsp_q, rsp_d;
  logic [CNT_W:0]   mid_sum;
  logic [IDX_W-1:0] mid;
  cell_flags_t      probe;

  // Midpoint of [lo, end-1], floor
  assign mid_sum = {1'b0, lo_q} + {1'b0, end_q} - (CNT_W + 1)'(1);
  assign mid     = mid_sum[IDX_W:1];
  assign probe   = flags_i[mid];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= PR_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q  <= lo_d;
    end_q <= end_d;
    rsp_q <= rsp_d;
  end

  // Next state and search window
  always_comb begin
    state_d = state_q;
    lo_d    = lo_q;
    end_d   = end_q;
    rsp_d   = rsp_q;
    unique case (state_q)
      PR_IDLE: begin
        if (start_i) begin
          lo_d    = '0;
          end_d   = count_i;
          state_d = PR_RUN;
        end
      end
      PR_RUN: begin
        if (lo_q >= end_q) begin
          rsp_d   = '0;
          state_d = PR_DONE;
        end else if (probe.eq) begin
          rsp_d.found    = 1'b1;
          rsp_d.position = POS_W'(mid);
          state_d        = PR_DONE;
        end else if (probe.lt) begin
          lo_d = CNT_W'(mid) + CNT_W'(1);
        end else begin
          end_d = CNT_W'(mid);
        end
      end
      PR_DONE: begin
        if (ack_i) begin
          state_d = PR_IDLE;
        end
      end
      default: begin
        state_d = PR_IDLE;
      end
    endcase
  end

  assign busy_o = state_q != PR_IDLE;
  assign done_o = state_q == PR_DONE;
  assign rsp_o  = rsp_q;

endmodule

// File: sv/sorted_store_binary_search.sv
// Top level of the sorted store: cell chain, entry count, result register.
// Depends on ssbs_pkg, ssbs_cell, ssbs_probe and the assertion macros header.
//
//   channel  direction  handshake               payload
//   in       request    in_valid_i/in_stall_o   in_req_i   (op, value)
//   out      result     out_valid_o/out_stall_i out_rsp_o  (found, position, dropped)
//
// Clear and load complete at once; a load moves each entry above its insert point up
// one cell. A search captures all compare flags, then makes one probe per cycle until
// a match or an empty window, then hands the result on once the output is free.
// One request is in flight at a time; a clear or load result parks beside a waiting
// output so the request still enters, then the input stalls until the park drains.
// Reset empties the store at once; entry contents are not cleared.
module sorted_store_binary_search (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  ssbs_pkg::ssbs_req_t in_req_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output ssbs_pkg::ssbs_rsp_t out_rsp_o
);
  import ssbs_pkg::*;
`include "sorted_store_binary_search_macros.svh"

  logic [CNT_W-1:0] count_q, count_d;
  logic             out_valid_q, out_valid_d;
  ssbs_rsp_t        out_q, out_d;
  logic             imm_valid_q, imm_valid_d;
  ssbs_rsp_t        imm_q, imm_d, imm_rsp;
  op_e              op;
  logic             acc, imm_acc, out_free, full, neg;
  logic             load_en, cmp_en;
  logic             probe_busy, probe_done;
  probe_rsp_t       probe_rsp;

  logic [VAL_W-1:0] vals [DEPTH+1];
  logic             gts  [DEPTH+1];
  cell_flags_t      flags [DEPTH];

  assign op       = op_e'(in_req_i.op);
  assign neg      = in_req_i.value[31];
  assign full     = count_q == CNT_W'(DEPTH);
  assign out_free = !out_valid_q || !out_stall_i;
  assign in_stall_o = probe_busy || imm_valid_q;
  assign acc      = in_valid_i && !in_stall_o;
  assign imm_acc  = acc && (op != OP_SEARCH);
  assign load_en  = acc && (op == OP_LOAD) && !neg && !full;
  assign cmp_en   = acc && (op == OP_SEARCH);

  // Chain of cells, each fed by its lower neighbor
  assign vals[0] = '0;
  assign gts[0]  = 1'b0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    ssbs_cell u_cell (
      .clk_i     (clk_i),
      .load_i    (load_en),
      .cmp_i     (cmp_en),
      .data_i    (in_req_i.value[VAL_W-1:0]),
      .key_neg_i (neg),
      .occ_i     (CNT_W'(i) < count_q),
      .tail_i    (CNT_W'(i) == count_q),
      .prev_val_i(vals[i]),
      .prev_gt_i (gts[i]),
      .val_o     (vals[i+1]),
      .gt_o      (gts[i+1]),
      .flags_o   (flags[i])
    );
  end

  ssbs_probe u_probe (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmp_en),
    .count_i(count_q),
    .flags_i(flags),
    .ack_i  (out_free),
    .busy_o (probe_busy),
    .done_o (probe_done),
    .rsp_o  (probe_rsp)
  );

  // Track the number of stored entries
  always_comb begin
    count_d = count_q;
    if (acc && (op == OP_CLEAR)) begin
      count_d = '0;
    end else if (load_en) begin
      count_d = count_q + CNT_W'(1);
    end
  end

  // Result of a request that completes at once
  always_comb begin
    imm_rsp         = '0;
    imm_rsp.dropped = (op == OP_LOAD) && !neg && full;
  end

  // Park an immediate result while the output register still waits
  always_comb begin
    imm_valid_d = imm_valid_q;
    imm_d       = imm_q;
    if (imm_acc && !out_free) begin
      imm_valid_d = 1'b1;
      imm_d       = imm_rsp;
    end else if (imm_valid_q && out_free) begin
      imm_valid_d = 1'b0;
    end
  end

  // Load the result register from an immediate request, the park or a finished search
  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (imm_acc && out_free) begin
      out_valid_d    = 1'b1;
      out_d          = imm_rsp;
    end else if (imm_valid_q && out_free) begin
      out_valid_d    = 1'b1;
      out_d          = imm_q;
    end else if (probe_done && out_free) begin
      out_valid_d    = 1'b1;
      out_d.found    = probe_rsp.found;
      out_d.position = probe_rsp.position;
      out_d.dropped  = 1'b0;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
      imm_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      imm_valid_q <= imm_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    imm_q <= imm_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  `SSBS_ASSERT_NEVER(a_count_max, clk_i, rst_ni, count_q > CNT_W'(DEPTH))
  `SSBS_ASSERT_NEVER(a_no_accept_busy, clk_i, rst_ni, probe_busy && acc)
  `SSBS_ASSERT_IMPL(a_load_count, clk_i, rst_ni, load_en |=> count_q == $past(count_q) + CNT_W'(1))
  `SSBS_ASSERT_IMPL(a_rsp_excl, clk_i, rst_ni, out_valid_q |-> !(out_q.found && out_q.dropped))

endmodule

// File: tb/sv/sorted_store_binary_search_tb.sv
// Self-checking testbench for sorted_store_binary_search: clear, load and search requests
// against a behavioral sorted store, with random idling on both channels.
// Depends on ssbs_pkg and the sorted_store_binary_search RTL.
module sorted_store_binary_search_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ssbs_pkg::*;

  // Op code left unused by the block
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int HOLD_CYCLES = 80;
  localparam int SETTLE_CYCLES = 20;
  localparam int RANDOM_ITEMS = 750;

  typedef struct {
    ssbs_req_t req;
    bit        wait_drain;
  } queued_req_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      req_valid = 1'b0;
  logic      req_stall;
  ssbs_req_t req = '0;
  logic      rsp_valid;
  logic      rsp_stall = 1'b0;
  ssbs_rsp_t rsp;

  queued_req_t request_q[$];
  ssbs_rsp_t   expected_rsp_q[$];
  logic [31:0] loaded_keys[$];

  // Behavioral copy of the sorted store
  logic [VAL_W-1:0] store_vals[DEPTH];
  int               store_count = 0;

  int requests_sent = 0;
  int results_seen = 0;
  int error_count = 0;
  int send_gap;
  int stall_left;
  int hold_left = 0;

  sorted_store_binary_search dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (req_valid),
    .in_stall_o (req_stall),
    .in_req_i   (req),
    .out_valid_o(rsp_valid),
    .out_stall_i(rsp_stall),
    .out_rsp_o  (rsp)
  );

  always #1 clk = ~clk;

  // Apply one request to the store and return the result it should give
  function automatic ssbs_rsp_t apply_to_store(ssbs_req_t r);
    ssbs_rsp_t res;
    int        pos;
    int        lo;
    int        hi;
    int        mid;
    bit        hit;
    res = '0;
    case (r.op)
      OP_CLEAR: begin
        store_count = 0;
      end
      OP_LOAD: begin
        // Negative values are ignored; a full store drops the value
        if (!r.value[31]) begin
          if (store_count >= DEPTH) begin
            res.dropped = 1'b1;
          end else begin
            pos = store_count;
            while (pos > 0 && store_vals[pos-1] > r.value[VAL_W-1:0]) begin
              store_vals[pos] = store_vals[pos-1];
              pos--;
            end
            store_vals[pos] = r.value[VAL_W-1:0];
            store_count++;
          end
        end
      end
      OP_SEARCH: begin
        // A negative key can never match a stored value
        if (!r.value[31]) begin
          lo = 0;
          hi = store_count - 1;
          hit = 1'b0;
          while (!hit && lo <= hi) begin
            mid = (lo + hi) / 2;
            if (store_vals[mid] == r.value[VAL_W-1:0]) begin
              hit = 1'b1;
              res.found = 1'b1;
              res.position = POS_W'(mid);
            end else if (store_vals[mid] < r.value[VAL_W-1:0]) begin
              lo = mid + 1;
            end else begin
              hi = mid - 1;
            end
          end
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  // Draw an idle count; every fourth window of 64 items runs without gaps
  function automatic int idle_cycles(int n);
    if ((n / 64) % 4 == 1) return 0;
    return $urandom_range(0, 14);
  endfunction

  function automatic void queue_request(logic [1:0] op, logic [31:0] value, bit wait_drain);
    queued_req_t item;
    item.req.op = op;
    item.req.value = value;
    item.wait_drain = wait_drain;
    request_q.push_back(item);
    // Track keys loaded since the last clear to aim searches at hits
    if (op == OP_CLEAR) loaded_keys.delete();
    else if (op == OP_LOAD && !value[31]) loaded_keys.push_back(value);
  endfunction

  function automatic logic [31:0] load_value();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 4) return $urandom_range(0, 31);
    if (pick < 7) return {1'b0, 31'($urandom())};
    if (pick == 7) return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h0;
    return $urandom();
  endfunction

  function automatic logic [31:0] search_key();
    int pick;
    int idx;
    pick = $urandom_range(0, 9);
    if (loaded_keys.size() > 0 && pick < 8) begin
      idx = $urandom_range(0, loaded_keys.size() - 1);
      // Mostly exact keys, some near misses
      return (pick < 6) ? loaded_keys[idx] : loaded_keys[idx] + 32'd1;
    end
    return $urandom();
  endfunction

  task automatic flag_error(string msg);
    $display("ERROR at %0t: %s", $time, msg);
    error_count++;
  endtask

  task automatic check_field(string name, int unsigned got, int unsigned want);
    if (got != want) begin
      flag_error($sformatf("result %0d: %s is %0d, expected %0d", results_seen, name, got, want));
    end
  endtask

  // Drive requests from the pending queue, idling between them
  always @(posedge clk or negedge rst_n) begin : drive_requests
    logic busy;
    if (!rst_n) begin
      req_valid <= 1'b0;
      req <= '0;
      send_gap = 0;
    end else begin
      busy = req_valid && req_stall;
      if (req_valid && !req_stall) begin
        expected_rsp_q.push_back(apply_to_store(req));
        requests_sent++;
        send_gap = idle_cycles(requests_sent);
      end
      // Hold a stalled request; otherwise idle, advance, or wait for a drain
      if (!busy) begin
        if (send_gap > 0) begin
          send_gap--;
          req_valid <= 1'b0;
        end else if (request_q.size() > 0 &&
                     !(request_q[0].wait_drain && requests_sent != results_seen)) begin
          req <= request_q[0].req;
          req_valid <= 1'b1;
          void'(request_q.pop_front());
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // Hold off the receiver for a long stretch at two points of the run
  always @(posedge clk or negedge rst_n) begin : hold_receiver
    if (!rst_n) begin
      hold_left <= 0;
    end else if (rsp_valid && !rsp_stall &&
                 (results_seen + 1 == 100 || results_seen + 1 == 900)) begin
      hold_left <= HOLD_CYCLES;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Take results, check them in order, and stall at random
  always @(posedge clk or negedge rst_n) begin : take_results
    ssbs_rsp_t want;
    if (!rst_n) begin
      rsp_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (expected_rsp_q.size() == 0) begin
          flag_error("result with no request pending");
        end else begin
          want = expected_rsp_q.pop_front();
          check_field("found", rsp.found, want.found);
          check_field("position", rsp.position, want.position);
          check_field("dropped", rsp.dropped, want.dropped);
        end
        results_seen <= results_seen + 1;
        stall_left = idle_cycles(results_seen + 1);
      end else if (rsp_valid && stall_left > 0) begin
        stall_left--;
      end
      rsp_stall <= (stall_left > 0) || (hold_left > 0);
    end
  end

  // Build stimulus, release reset, then wait for all results
  initial begin : run_stimulus
    int fill_items;
    int base;
    int seq_kind;
    fill_items = 0;

    // Directed: empty search, extremes, negatives, duplicates, unused op, clear
    queue_request(OP_SEARCH, 32'd5, 1'b0);
    queue_request(OP_LOAD, 32'h7FFF_FFFF, 1'b0);
    queue_request(OP_LOAD, 32'h0, 1'b0);
    queue_request(OP_LOAD, 32'h8000_0000, 1'b0);
    queue_request(OP_LOAD, 32'hFFFF_FFFF, 1'b0);
    repeat (3) queue_request(OP_LOAD, 32'd100, 1'b0);
    queue_request(OP_SEARCH, 32'h0, 1'b0);
    queue_request(OP_SEARCH, 32'h7FFF_FFFF, 1'b0);
    queue_request(OP_SEARCH, 32'd100, 1'b0);
    queue_request(OP_SEARCH, 32'd50, 1'b0);
    queue_request(OP_SEARCH, 32'hFFFF_FFFF, 1'b0);
    queue_request(OP_SEARCH, 32'h8000_0000, 1'b0);
    queue_request(OP_UNUSED, 32'hFFFF_FFFF, 1'b0);
    queue_request(OP_UNUSED, 32'h0, 1'b0);
    queue_request(OP_CLEAR, 32'hDEAD_BEEF, 1'b0);
    queue_request(OP_SEARCH, 32'd100, 1'b1);
    queue_request(OP_LOAD, 32'd7, 1'b0);
    queue_request(OP_SEARCH, 32'd7, 1'b0);
    base = request_q.size();

    // Random: mostly clear/load/search sequences, some noise, one full-store fill
    while (request_q.size() < base + RANDOM_ITEMS + fill_items) begin
      if (fill_items == 0 && request_q.size() > base + 300) begin
        fill_items = request_q.size();
        queue_request(OP_CLEAR, 32'h0, 1'b1);
        queue_request(OP_LOAD, 32'h7FFF_FFFF, 1'b0);
        repeat (DEPTH + 5) queue_request(OP_LOAD, $urandom_range(0, 4000), 1'b0);
        queue_request(OP_LOAD, 32'hFFFF_FFFF, 1'b0);
        queue_request(OP_SEARCH, 32'h7FFF_FFFF, 1'b0);
        repeat (40) queue_request(OP_SEARCH, search_key(), 1'b0);
        fill_items = request_q.size() - fill_items;
      end
      seq_kind = $urandom_range(0, 9);
      if (seq_kind < 7) begin
        if ($urandom_range(0, 2) != 0) begin
          queue_request(OP_CLEAR, $urandom(), $urandom_range(0, 7) == 0);
        end
        repeat ($urandom_range(1, 40)) queue_request(OP_LOAD, load_value(), 1'b0);
        repeat ($urandom_range(1, 20)) queue_request(OP_SEARCH, search_key(), 1'b0);
      end else begin
        repeat ($urandom_range(1, 10)) queue_request(2'($urandom_range(0, 3)), $urandom(), 1'b0);
      end
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    do @(posedge clk);
    while (request_q.size() != 0 || req_valid || expected_rsp_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Stop a hung run
  initial begin : watchdog
    #1ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
